/* rtl/ipsd_pkg.sv */
package ipsd_pkg;

    // Default sine table resolution, in address bits over one full turn.
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Voltage command limit, plus or minus one in Q2.14.
    localparam int VOLT_LIMIT = 16384;

    // sin(60 degrees) in Q30.
    localparam logic signed [30:0] SIN60_Q30 = 31'sd929887697;

    // Pi/2 in Q30, used while the sine tables of the design and the checker are built.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Widths of the fixed-point intermediate values.
    localparam int PROD_W  = 30;  // d*cos and friends, Q28
    localparam int AB_W    = 31;  // alpha and beta, Q28
    localparam int SQ_W    = 60;  // alpha^2 and beta^2, Q56
    localparam int P_W     = 61;  // sin60 * alpha, Q58
    localparam int TIME_W  = 62;  // active vector times, Q58
    localparam int DUTY2_W = 63;  // doubled duty, Q59
    localparam int DUTY_W  = 16;

    typedef logic [2:0] sector_t;
    typedef logic signed [TIME_W-1:0] vtime_t;
    typedef logic signed [DUTY2_W-1:0] duty2_t;

    // Sector numbers.
    localparam sector_t SECT_1 = 3'd1;
    localparam sector_t SECT_2 = 3'd2;
    localparam sector_t SECT_3 = 3'd3;
    localparam sector_t SECT_4 = 3'd4;
    localparam sector_t SECT_5 = 3'd5;
    localparam sector_t SECT_6 = 3'd6;

    // First-quadrant sine in Q14 for k in 0..2^(bits-2), Taylor series to x^11.
    // Only evaluated with constant arguments while the table is built.
    function automatic logic [14:0] quarter_sine(input int k, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] r;
        x = (64'(k) * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        term = x;
        sum = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - signed'(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        r = (unsigned'(sum) + 64'd32768) >> 16;
        if (r > 64'(VOLT_LIMIT))
        begin
            r = 64'(VOLT_LIMIT);
        end
        return r[14:0];
    endfunction

    // Sector from {beta > 0, beta^2 > 3 alpha^2, alpha > 0}.
    function automatic sector_t sector_of(input logic [2:0] key);
        sector_t s;
        unique case (key)
            3'd0:    s = SECT_4;
            3'd1:    s = SECT_6;
            3'd2:    s = SECT_5;
            3'd3:    s = SECT_5;
            3'd4:    s = SECT_3;
            3'd5:    s = SECT_1;
            3'd6:    s = SECT_2;
            default: s = SECT_2;
        endcase
        return s;
    endfunction

    // Sector that follows, wrapping from six back to one.
    function automatic sector_t next_sector(input sector_t s);
        sector_t n;
        unique case (s)
            SECT_1:  n = SECT_2;
            SECT_2:  n = SECT_3;
            SECT_3:  n = SECT_4;
            SECT_4:  n = SECT_5;
            SECT_5:  n = SECT_6;
            default: n = SECT_1;
        endcase
        return n;
    endfunction

    // Switching vector of a sector: bit 0 is phase U, bit 1 V, bit 2 W.
    function automatic logic [2:0] vec_on(input sector_t s);
        logic [2:0] v;
        unique case (s)
            SECT_1:  v = 3'b001;
            SECT_2:  v = 3'b011;
            SECT_3:  v = 3'b010;
            SECT_4:  v = 3'b110;
            SECT_5:  v = 3'b100;
            default: v = 3'b101;
        endcase
        return v;
    endfunction

endpackage

/* rtl/inverse_park_svpwm_duty_top.sv */
// Each of the 8 stages holds one item with its valid bit; an accepted item runs through
// all stages to the output register. Throughput: one item per cycle without a stall.
// A stall holds the last stage and full stages behind it; bubbles upstream take new items.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers keep
// their contents. The sine table is constant, so no clearing pass follows reset.
module inverse_park_svpwm_duty_top #(
    parameter int SINE_TABLE_BITS = ipsd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // volt_d[15:0], volt_q[31:16], rotor_angle[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // duty_u[15:0], duty_v[31:16], duty_w[47:32]
    output logic [3:0]  m_tuser    // sector_num[2:0], over_modulation[3]
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv_chain;
    logic [STAGES-1:0] stage_en;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv_chain[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv_chain[k] = !valid_reg[k] || adv_chain[k+1];
        end
        stage_en = adv_chain[STAGES-1:0];
    end

    always_comb
    begin
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];

    // Datapath.
    logic signed [15:0]                   d_s;
    logic signed [15:0]                   q_s;
    logic signed [15:0]                   sin_s;
    logic signed [15:0]                   cos_s;
    logic signed [ipsd_pkg::AB_W-1:0]     alpha_s;
    logic signed [ipsd_pkg::AB_W-1:0]     beta_s;
    ipsd_pkg::vtime_t                     tm_s;
    ipsd_pkg::vtime_t                     tn_s;
    ipsd_pkg::sector_t                    sect_s;
    logic [ipsd_pkg::DUTY_W-1:0]          duty_u;
    logic [ipsd_pkg::DUTY_W-1:0]          duty_v;
    logic [ipsd_pkg::DUTY_W-1:0]          duty_w;
    ipsd_pkg::sector_t                    sector_num;
    logic                                 over_modulation;

    ipsd_sincos #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sincos (
        .clk        (clk),
        .en         (stage_en[0]),
        .volt_d     (s_tdata[15:0]),
        .volt_q     (s_tdata[31:16]),
        .rotor_angle(s_tdata[47:32]),
        .d_reg      (d_s),
        .q_reg      (q_s),
        .sin_reg    (sin_s),
        .cos_reg    (cos_s)
    );

    ipsd_rotate u_rotate (
        .clk      (clk),
        .en       (stage_en[2:1]),
        .d_in     (d_s),
        .q_in     (q_s),
        .sin_in   (sin_s),
        .cos_in   (cos_s),
        .alpha_reg(alpha_s),
        .beta_reg (beta_s)
    );

    ipsd_sector u_sector (
        .clk     (clk),
        .en      (stage_en[5:3]),
        .alpha_in(alpha_s),
        .beta_in (beta_s),
        .tm_reg  (tm_s),
        .tn_reg  (tn_s),
        .sect_reg(sect_s)
    );

    ipsd_duty u_duty (
        .clk       (clk),
        .en        (stage_en[7:6]),
        .tm_in     (tm_s),
        .tn_in     (tn_s),
        .sect_in   (sect_s),
        .duty_u_reg(duty_u),
        .duty_v_reg(duty_v),
        .duty_w_reg(duty_w),
        .sect_reg  (sector_num),
        .ovm_reg   (over_modulation)
    );

    assign m_tdata = {duty_w, duty_v, duty_u};
    assign m_tuser = {over_modulation, sector_num};

`ifndef NO_ASSERTIONS
    // A delivered sector is always one of one through six.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:0] != 3'd0 && m_tuser[2:0] != 3'd7))
        else $error("sector out of range");

    // With a negative zero time, the phase off in both vectors clips to zero.
    a_ovm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |->
            (m_tdata[15:0] == 16'd0 || m_tdata[31:16] == 16'd0 || m_tdata[47:32] == 16'd0))
        else $error("over-modulation without a clipped phase");

    // An empty output register means the whole pipeline can take an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");
`endif

endmodule

/* rtl/ipsd_sincos.sv */
module ipsd_sincos #(
    parameter int SINE_TABLE_BITS = ipsd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] volt_d,
    input  logic signed [15:0] volt_q,
    input  logic [15:0]        rotor_angle,
    output logic signed [15:0] d_reg,
    output logic signed [15:0] q_reg,
    output logic signed [15:0] sin_reg,
    output logic signed [15:0] cos_reg
);

    localparam int KW = SINE_TABLE_BITS - 2;
    localparam int QN = 1 << KW;

    // Quarter-wave sine table, built at elaboration.
    logic [14:0] qtab [QN+1];

    for (genvar g = 0; g <= QN; g++)
    begin : g_qtab
        assign qtab[g] = ipsd_pkg::quarter_sine(g, SINE_TABLE_BITS);
    end

    logic [SINE_TABLE_BITS-1:0] sin_idx;
    logic [SINE_TABLE_BITS-1:0] cos_idx;
    logic [KW:0]                sin_addr;
    logic [KW:0]                cos_addr;
    logic [14:0]                sin_mag;
    logic [14:0]                cos_mag;
    logic signed [15:0]         d_next;
    logic signed [15:0]         q_next;
    logic signed [15:0]         sin_next;
    logic signed [15:0]         cos_next;

    // Table index from the angle; cosine is a quarter turn ahead.
    assign sin_idx = rotor_angle[15 -: SINE_TABLE_BITS];
    assign cos_idx = sin_idx + SINE_TABLE_BITS'(QN);

    // Odd quadrants read the table mirrored, the upper half negates.
    always_comb
    begin
        if (sin_idx[KW])
        begin
            sin_addr = (KW+1)'(QN) - {1'b0, sin_idx[KW-1:0]};
        end
        else
        begin
            sin_addr = {1'b0, sin_idx[KW-1:0]};
        end
        if (cos_idx[KW])
        begin
            cos_addr = (KW+1)'(QN) - {1'b0, cos_idx[KW-1:0]};
        end
        else
        begin
            cos_addr = {1'b0, cos_idx[KW-1:0]};
        end
        sin_mag = qtab[sin_addr];
        cos_mag = qtab[cos_addr];
        sin_next = sin_idx[KW+1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_next = cos_idx[KW+1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    end

    // Clamp both commands to plus or minus one.
    always_comb
    begin
        d_next = volt_d;
        q_next = volt_q;
        if (volt_d > 16'sd16384)
        begin
            d_next = 16'sd16384;
        end
        else if (volt_d < -16'sd16384)
        begin
            d_next = -16'sd16384;
        end
        if (volt_q > 16'sd16384)
        begin
            q_next = 16'sd16384;
        end
        else if (volt_q < -16'sd16384)
        begin
            q_next = -16'sd16384;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            q_reg   <= q_next;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

endmodule

/* rtl/ipsd_rotate.sv */
module ipsd_rotate (
    input  logic                                 clk,
    input  logic [1:0]                           en,
    input  logic signed [15:0]                   d_in,
    input  logic signed [15:0]                   q_in,
    input  logic signed [15:0]                   sin_in,
    input  logic signed [15:0]                   cos_in,
    output logic signed [ipsd_pkg::AB_W-1:0]     alpha_reg,
    output logic signed [ipsd_pkg::AB_W-1:0]     beta_reg
);

    logic signed [ipsd_pkg::PROD_W-1:0] dc_reg;
    logic signed [ipsd_pkg::PROD_W-1:0] qs_reg;
    logic signed [ipsd_pkg::PROD_W-1:0] ds_reg;
    logic signed [ipsd_pkg::PROD_W-1:0] qc_reg;
    logic signed [31:0]                 dc_full;
    logic signed [31:0]                 qs_full;
    logic signed [31:0]                 ds_full;
    logic signed [31:0]                 qc_full;
    logic signed [ipsd_pkg::AB_W-1:0]   alpha_next;
    logic signed [ipsd_pkg::AB_W-1:0]   beta_next;

    // Four products of the inverse Park rotation; each fits in Q28.
    assign dc_full = d_in * cos_in;
    assign qs_full = q_in * sin_in;
    assign ds_full = d_in * sin_in;
    assign qc_full = q_in * cos_in;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dc_reg <= dc_full[ipsd_pkg::PROD_W-1:0];
            qs_reg <= qs_full[ipsd_pkg::PROD_W-1:0];
            ds_reg <= ds_full[ipsd_pkg::PROD_W-1:0];
            qc_reg <= qc_full[ipsd_pkg::PROD_W-1:0];
        end
    end

    // alpha = d cos - q sin, beta = d sin + q cos.
    assign alpha_next = ipsd_pkg::AB_W'(dc_reg) - ipsd_pkg::AB_W'(qs_reg);
    assign beta_next  = ipsd_pkg::AB_W'(ds_reg) + ipsd_pkg::AB_W'(qc_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
    end

endmodule

/* rtl/ipsd_sector.sv */
module ipsd_sector (
    input  logic                             clk,
    input  logic [2:0]                       en,
    input  logic signed [ipsd_pkg::AB_W-1:0] alpha_in,
    input  logic signed [ipsd_pkg::AB_W-1:0] beta_in,
    output ipsd_pkg::vtime_t                 tm_reg,
    output ipsd_pkg::vtime_t                 tn_reg,
    output ipsd_pkg::sector_t                sect_reg
);

    localparam int AW = ipsd_pkg::AB_W;

    // Stage one: magnitudes squared and sin60 * alpha.
    logic [AW-2:0]                    abs_a;
    logic [AW-2:0]                    abs_b;
    logic [ipsd_pkg::SQ_W-1:0]        sqa_reg;
    logic [ipsd_pkg::SQ_W-1:0]        sqb_reg;
    logic signed [ipsd_pkg::P_W-1:0]  p1_reg;
    logic signed [AW-1:0]             beta1_reg;
    logic                             apos_reg;
    logic                             bpos_reg;

    assign abs_a = alpha_in[AW-1] ? (AW-1)'(-alpha_in) : alpha_in[AW-2:0];
    assign abs_b = beta_in[AW-1] ? (AW-1)'(-beta_in) : beta_in[AW-2:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqa_reg   <= ipsd_pkg::SQ_W'(abs_a) * ipsd_pkg::SQ_W'(abs_a);
            sqb_reg   <= ipsd_pkg::SQ_W'(abs_b) * ipsd_pkg::SQ_W'(abs_b);
            p1_reg    <= ipsd_pkg::P_W'(alpha_in) * ipsd_pkg::P_W'(ipsd_pkg::SIN60_Q30);
            beta1_reg <= beta_in;
            apos_reg  <= (alpha_in > 0);
            bpos_reg  <= (beta_in > 0);
        end
    end

    // Stage two: exact compare of beta^2 against 3 alpha^2, sector lookup.
    logic [ipsd_pkg::SQ_W+1:0]        sqa3;
    logic [2:0]                       key;
    ipsd_pkg::sector_t                sect2_next;
    ipsd_pkg::sector_t                sect2_reg;
    logic signed [ipsd_pkg::P_W-1:0]  p2_reg;
    logic signed [AW-1:0]             beta2_reg;

    assign sqa3 = {1'b0, sqa_reg, 1'b0} + {2'b00, sqa_reg};
    assign key = {bpos_reg, ({2'b00, sqb_reg} > sqa3), apos_reg};
    assign sect2_next = ipsd_pkg::sector_of(key);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sect2_reg <= sect2_next;
            p2_reg    <= p1_reg;
            beta2_reg <= beta1_reg;
        end
    end

    // Stage three: active vector times from sin60 * alpha and shifted beta.
    ipsd_pkg::vtime_t pw;
    ipsd_pkg::vtime_t bh;
    ipsd_pkg::vtime_t bf;
    ipsd_pkg::vtime_t tm_next;
    ipsd_pkg::vtime_t tn_next;

    assign pw = ipsd_pkg::TIME_W'(p2_reg);
    assign bh = ipsd_pkg::TIME_W'(beta2_reg) <<< 29;
    assign bf = ipsd_pkg::TIME_W'(beta2_reg) <<< 30;

    always_comb
    begin
        unique case (sect2_reg)
            ipsd_pkg::SECT_1:
            begin
                tm_next = pw - bh;
                tn_next = bf;
            end
            ipsd_pkg::SECT_2:
            begin
                tm_next = pw + bh;
                tn_next = bh - pw;
            end
            ipsd_pkg::SECT_3:
            begin
                tm_next = bf;
                tn_next = -bh - pw;
            end
            ipsd_pkg::SECT_4:
            begin
                tm_next = bh - pw;
                tn_next = -bf;
            end
            ipsd_pkg::SECT_5:
            begin
                tm_next = -pw - bh;
                tn_next = pw - bh;
            end
            default:
            begin
                tm_next = -bf;
                tn_next = pw + bh;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            tm_reg   <= tm_next;
            tn_reg   <= tn_next;
            sect_reg <= sect2_reg;
        end
    end

endmodule

/* rtl/ipsd_duty.sv */
module ipsd_duty (
    input  logic                            clk,
    input  logic [1:0]                      en,
    input  ipsd_pkg::vtime_t                tm_in,
    input  ipsd_pkg::vtime_t                tn_in,
    input  ipsd_pkg::sector_t               sect_in,
    output logic [ipsd_pkg::DUTY_W-1:0]     duty_u_reg,
    output logic [ipsd_pkg::DUTY_W-1:0]     duty_v_reg,
    output logic [ipsd_pkg::DUTY_W-1:0]     duty_w_reg,
    output ipsd_pkg::sector_t               sect_reg,
    output logic                            ovm_reg
);

    localparam ipsd_pkg::duty2_t ONE_Q58 = ipsd_pkg::duty2_t'(1) <<< 58;

    logic [2:0]        on_a;
    logic [2:0]        on_b;
    ipsd_pkg::duty2_t  tm_w;
    ipsd_pkg::duty2_t  tn_w;
    ipsd_pkg::duty2_t  t0;
    ipsd_pkg::duty2_t  d2_next [3];
    ipsd_pkg::duty2_t  d2_reg [3];
    ipsd_pkg::sector_t sect1_reg;
    logic              neg1_reg;

    assign on_a = ipsd_pkg::vec_on(sect_in);
    assign on_b = ipsd_pkg::vec_on(ipsd_pkg::next_sector(sect_in));
    assign tm_w = ipsd_pkg::DUTY2_W'(tm_in);
    assign tn_w = ipsd_pkg::DUTY2_W'(tn_in);
    assign t0   = ONE_Q58 - tm_w - tn_w;

    // Doubled duty t0 + 2 a tm + 2 b tn, written as one three-input sum per phase.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d2_next[j] = ONE_Q58 + (on_a[j] ? tm_w : -tm_w) + (on_b[j] ? tn_w : -tn_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d2_reg    <= d2_next;
            sect1_reg <= sect_in;
            neg1_reg  <= t0[ipsd_pkg::DUTY2_W-1];
        end
    end

    // Round the Q59 doubled duty to Q0.16 and saturate.
    function automatic logic [ipsd_pkg::DUTY_W-1:0] to_duty(input ipsd_pkg::duty2_t d2);
        logic [ipsd_pkg::DUTY2_W-1:0] r;
        logic [ipsd_pkg::DUTY_W-1:0]  res;
        r = (unsigned'(d2) + (ipsd_pkg::DUTY2_W'(1) << 42)) >> 43;
        if (d2 <= 0)
        begin
            res = '0;
        end
        else if (r > ipsd_pkg::DUTY2_W'(16'hFFFF))
        begin
            res = '1;
        end
        else
        begin
            res = r[ipsd_pkg::DUTY_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            duty_u_reg <= to_duty(d2_reg[0]);
            duty_v_reg <= to_duty(d2_reg[1]);
            duty_w_reg <= to_duty(d2_reg[2]);
            sect_reg   <= sect1_reg;
            ovm_reg    <= neg1_reg;
        end
    end

endmodule

/* tb/sv/svpwm_duty_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the inverse Park / SVPWM duty block, predicts the
// duty set for every accepted command, and compares each delivered duty set
// with the oldest prediction still waiting.
module svpwm_duty_checker #(
    parameter int TABLE_BITS = ipsd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // volt_d[15:0], volt_q[31:16], rotor_angle[47:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // duty_u[15:0], duty_v[31:16], duty_w[47:32]
    input  logic [3:0]  m_tuser,   // sector_num[2:0], over_modulation[3]
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          overmod_seen,
    output logic [7:0]  sector_hits
);

    localparam int REPORT_LIMIT = 10;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;

    typedef struct packed {
        logic [15:0]       duty_u;
        logic [15:0]       duty_v;
        logic [15:0]       duty_w;
        ipsd_pkg::sector_t sector;
        logic              over_mod;
    } duty_set_t;

    duty_set_t duty_sets_due [$];

    // First-quadrant sine in Q14 from a truncated Taylor series in Q30.
    function automatic longint quarter_wave(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        longint      rounded;
        x = (64'(k) * ipsd_pkg::HALF_PI_Q30) >> (TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        rounded = (acc + 64'sd32768) >>> 16;
        return (rounded > ipsd_pkg::VOLT_LIMIT) ? longint'(ipsd_pkg::VOLT_LIMIT) : rounded;
    endfunction

    // Full-turn sine table entry, built from the first quadrant by symmetry.
    function automatic longint wave_at(input int unsigned idx);
        int unsigned quadrant;
        int unsigned k;
        longint      mag;
        quadrant = (idx >> (TABLE_BITS - 2)) & 3;
        k = idx & (QUARTER - 1);
        mag = quadrant[0] ? quarter_wave(QUARTER - k) : quarter_wave(k);
        return quadrant[1] ? -mag : mag;
    endfunction

    // Voltage command limited to plus or minus one.
    function automatic longint limit_cmd(input logic [15:0] raw);
        longint v;
        v = longint'(signed'(raw));
        if (v > ipsd_pkg::VOLT_LIMIT)
        begin
            v = ipsd_pkg::VOLT_LIMIT;
        end
        if (v < -ipsd_pkg::VOLT_LIMIT)
        begin
            v = -ipsd_pkg::VOLT_LIMIT;
        end
        return v;
    endfunction

    function automatic ipsd_pkg::sector_t sector_from_key(input logic [2:0] key);
        case (key)
            3'd0:    return ipsd_pkg::SECT_4;
            3'd1:    return ipsd_pkg::SECT_6;
            3'd2:    return ipsd_pkg::SECT_5;
            3'd3:    return ipsd_pkg::SECT_5;
            3'd4:    return ipsd_pkg::SECT_3;
            3'd5:    return ipsd_pkg::SECT_1;
            default: return ipsd_pkg::SECT_2;
        endcase
    endfunction

    // sin and cos of k times 60 degrees, Q30.
    function automatic longint sin_sixty(input int k);
        case (k)
            1, 2:    return longint'(ipsd_pkg::SIN60_Q30);
            4, 5:    return -longint'(ipsd_pkg::SIN60_Q30);
            default: return 0;
        endcase
    endfunction

    function automatic longint cos_sixty(input int k);
        case (k)
            1, 5:    return HALF_Q30;
            2, 4:    return -HALF_Q30;
            3:       return -ONE_Q30;
            default: return ONE_Q30;
        endcase
    endfunction

    // Phases switched high by the active vector of a sector; bit 0 is U.
    function automatic logic [2:0] phases_high(input int s);
        case (s)
            1:       return 3'b001;
            2:       return 3'b011;
            3:       return 3'b010;
            4:       return 3'b110;
            5:       return 3'b100;
            default: return 3'b101;
        endcase
    endfunction

    // Doubled duty in Q59 rounded and saturated to Q0.16.
    function automatic logic [15:0] duty_from_q59(input longint twice);
        longint r;
        r = 0;
        if (twice > 0)
        begin
            r = (twice + (longint'(1) <<< 42)) >>> 43;
            if (r > 65535)
            begin
                r = 65535;
            end
        end
        return r[15:0];
    endfunction

    function automatic duty_set_t predict_duties(input logic [47:0] cmd);
        duty_set_t   res;
        longint      d, q, sn, cs, alpha, beta, aa, bb, tm, tn, t0, twice;
        int unsigned idx;
        int          s;
        logic [2:0]  on_a;
        logic [2:0]  on_b;
        logic [15:0] duties [3];
        d = limit_cmd(cmd[15:0]);
        q = limit_cmd(cmd[31:16]);
        idx = 32'(cmd[47:32]) >> (16 - TABLE_BITS);
        sn = wave_at(idx);
        cs = wave_at((idx + QUARTER) & ((1 << TABLE_BITS) - 1));
        alpha = d * cs - q * sn;
        beta = d * sn + q * cs;
        aa = (alpha < 0) ? -alpha : alpha;
        bb = (beta < 0) ? -beta : beta;
        res.sector = sector_from_key({beta > 0, bb * bb > 3 * aa * aa, alpha > 0});
        s = int'(res.sector);
        tm = sin_sixty(s) * alpha - cos_sixty(s) * beta;
        tn = cos_sixty(s - 1) * beta - sin_sixty(s - 1) * alpha;
        t0 = (longint'(1) <<< 58) - tm - tn;
        on_a = phases_high(s);
        on_b = phases_high(s % 6 + 1);
        for (int ph = 0; ph < 3; ph++)
        begin
            twice = t0;
            if (on_a[ph])
            begin
                twice = twice + 2 * tm;
            end
            if (on_b[ph])
            begin
                twice = twice + 2 * tn;
            end
            duties[ph] = duty_from_q59(twice);
        end
        res.duty_u = duties[0];
        res.duty_v = duties[1];
        res.duty_w = duties[2];
        res.over_mod = (t0 < 0);
        return res;
    endfunction

    // Queue a prediction for each accepted command, check each accepted duty set.
    always @(posedge clk)
    begin : watch
        duty_set_t want;
        duty_set_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                duty_sets_due.push_back(predict_duties(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.duty_u = m_tdata[15:0];
                got.duty_v = m_tdata[31:16];
                got.duty_w = m_tdata[47:32];
                got.sector = m_tuser[2:0];
                got.over_mod = m_tuser[3];
                if (duty_sets_due.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: duty set with no command outstanding: u=%0d v=%0d w=%0d",
                                 $realtime, got.duty_u, got.duty_v, got.duty_w);
                    end
                end
                else
                begin
                    want = duty_sets_due.pop_front();
                    if (got.duty_u !== want.duty_u || got.duty_v !== want.duty_v ||
                        got.duty_w !== want.duty_w || got.sector !== want.sector ||
                        got.over_mod !== want.over_mod)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: duty set %0d differs", $realtime, results_seen);
                            $display("    expected u=%0d v=%0d w=%0d sector=%0d ovm=%0d",
                                     want.duty_u, want.duty_v, want.duty_w,
                                     want.sector, want.over_mod);
                            $display("    actual   u=%0d v=%0d w=%0d sector=%0d ovm=%0d",
                                     got.duty_u, got.duty_v, got.duty_w,
                                     got.sector, got.over_mod);
                        end
                    end
                    sector_hits[want.sector] = 1'b1;
                    if (want.over_mod)
                    begin
                        overmod_seen = overmod_seen + 1;
                    end
                end
                results_seen = results_seen + 1;
            end
            pending = duty_sets_due.size();
        end
        else
        begin
            sector_hits = '0;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 1625;
    localparam int MID_DRAIN_AT = 800;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_POINTS [2] = '{350, 1100};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // volt_d[15:0], volt_q[31:16], rotor_angle[47:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // duty_u[15:0], duty_v[31:16], duty_w[47:32]
    logic [3:0]  m_tuser;   // sector_num[2:0], over_modulation[3]

    int          fail_count;
    int          pending;
    int          results_seen;
    int          overmod_seen;
    logic [7:0]  sector_hits;
    int          commands_sent;
    int          idle_cycles;

    inverse_park_svpwm_duty_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    svpwm_duty_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .overmod_seen (overmod_seen),
        .sector_hits  (sector_hits)
    );

    // 100 MHz clock.
    always #5 clk = ~clk;

    function automatic logic [47:0] pack_cmd(input int d, input int q, input int ang);
        return {ang[15:0], q[15:0], d[15:0]};
    endfunction

    // Random command: mostly in range, some in the linear region, some raw,
    // and some on a single axis near a quadrant boundary.
    function automatic logic [47:0] random_command();
        int pick;
        int d;
        int q;
        int ang;
        pick = $urandom_range(0, 99);
        ang = $urandom_range(0, 65535);
        if (pick < 55)
        begin
            d = $urandom_range(0, 32768) - 16384;
            q = $urandom_range(0, 32768) - 16384;
        end
        else if (pick < 75)
        begin
            d = $urandom_range(0, 18000) - 9000;
            q = $urandom_range(0, 18000) - 9000;
        end
        else if (pick < 90)
        begin
            d = $urandom_range(0, 65535);
            q = $urandom_range(0, 65535);
        end
        else
        begin
            d = $urandom_range(0, 32768) - 16384;
            q = 0;
            if ($urandom_range(0, 1) == 1)
            begin
                q = d;
                d = 0;
            end
            ang = ($urandom_range(0, 3) << 14) + $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1)
            begin
                ang = (ang - 64) & 16'hFFFF;
            end
        end
        return pack_cmd(d, q, ang);
    endfunction

    // Present one command and hold it until the block takes it.
    task automatic offer_command(input logic [47:0] cmd);
        s_tdata <= cmd;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        commands_sent = commands_sent + 1;
    endtask

    // Drop valid for a while, with junk on the data lines.
    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata <= {16'($urandom), 32'($urandom)};
        repeat (cycles)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding duty set has come back.
    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Command stream: directed corners, then random bursts with gaps.
    initial
    begin : sender
        logic [47:0] directed [$];
        int          burst_left;
        int          total;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        commands_sent = 0;

        // Zero vector, each axis at full scale, clamped commands, overmodulation,
        // tiny commands and angles on the table step and quadrant boundaries.
        directed.push_back(pack_cmd(0, 0, 0));
        directed.push_back(pack_cmd(16384, 0, 0));
        directed.push_back(pack_cmd(0, 16384, 0));
        directed.push_back(pack_cmd(-16384, 0, 0));
        directed.push_back(pack_cmd(0, -16384, 0));
        directed.push_back(pack_cmd(32767, 32767, 16'h1234));
        directed.push_back(pack_cmd(-32768, -32768, 16'hFFFF));
        directed.push_back(pack_cmd(16385, -16385, 16'h8000));
        directed.push_back(pack_cmd(16384, 16384, 16'h4000));
        directed.push_back(pack_cmd(9459, 0, 0));
        directed.push_back(pack_cmd(0, 9459, 16'hC000));
        directed.push_back(pack_cmd(1, 0, 16'h003F));
        directed.push_back(pack_cmd(-1, 0, 16'hFFC0));
        directed.push_back(pack_cmd(0, 1, 16'h0040));
        directed.push_back(pack_cmd(16384, 0, 16'h1555));
        directed.push_back(pack_cmd(10923, 0, 16'h2AAA));
        directed.push_back(pack_cmd(10923, 0, 0));
        directed.push_back(pack_cmd(8192, -8192, 16'hA000));
        directed.push_back(pack_cmd(16383, -16383, 16'h5555));
        directed.push_back(pack_cmd(32767, 0, 16'h7FFF));
        directed.push_back(pack_cmd(-32768, 32767, 16'h0001));
        directed.push_back(pack_cmd(12000, 5000, 16'hE000));
        directed.push_back(pack_cmd(0, 0, 16'hFFFF));
        directed.push_back(pack_cmd(5461, 5461, 16'h3000));

        repeat (10)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part back to back, then settle.
        foreach (directed[i])
        begin
            offer_command(directed[i]);
        end
        drain_all();

        // Random part in bursts.
        total = RANDOM_ITEMS;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < total; i++)
        begin
            offer_command(random_command());
            burst_left = burst_left - 1;
            if (i == MID_DRAIN_AT)
            begin
                drain_all();
            end
            else if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 1) == 1)
                begin
                    idle_sender($urandom_range(1, 12));
                end
            end
        end
        drain_all();

        repeat (20)
        begin
            @(posedge clk);
        end
        $display("Run summary: %0d commands sent, %0d duty sets checked, %0d over-modulated.",
                 commands_sent, results_seen, overmod_seen);
        $display("Sectors reached (6 down to 1): %b", sector_hits[6:1]);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result side: ready patterns of random length, plus long hold-offs that
    // let the pipeline fill and push back on the command side.
    initial
    begin : receiver
        int mode;
        int seg_len;
        int hold_idx;
        int cyc;
        m_tready = 1'b0;
        hold_idx = 0;
        cyc = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(16, 160);
            repeat (seg_len)
            begin
                cyc = cyc + 1;
                if (hold_idx < 2 && results_seen >= HOLD_POINTS[hold_idx])
                begin
                    hold_idx = hold_idx + 1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD)
                    begin
                        @(posedge clk);
                    end
                end
                else
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= (cyc % 3 == 0);
                        default: m_tready <= ($urandom_range(0, 99) < 85);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d duty sets outstanding.",
                     IDLE_LIMIT, pending);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
